@@ hdl/rau_pkg.sv @@
// Shared types and constants for the rational arithmetic unit.
// No dependencies; imported by every module in hdl/.
package rau_pkg;
	localparam int OpW = 32;
	localparam int MagW = 2 * OpW + 1;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2,
		OP_DIV = 3'd3, OP_EQ = 3'd4, OP_NORM = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_DIVZERO = 2'd1, ST_OVERFLOW = 2'd2, ST_ZERODEN = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic signed [OpW-1:0] left_num;
		logic signed [OpW-1:0] left_den;
		logic signed [OpW-1:0] right_num;
		logic signed [OpW-1:0] right_den;
	} req_t;

	typedef struct packed {
		logic signed [OpW-1:0] res_num;
		logic [OpW-2:0] res_den;
		logic is_equal;
		logic [1:0] status;
	} rsp_t;

	// Classified job handed from the front to the back.
	typedef struct packed {
		logic direct;          // result is final, no reduction needed
		rsp_t rsp;             // final result when direct
		logic neg;             // sign of the reduced result
		logic [MagW-1:0] n;    // numerator magnitude
		logic [MagW-1:0] d;    // denominator magnitude
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_GCD, BK_DIVN, BK_DIVD, BK_OUT
	} bk_state_t;
endpackage

@@ hdl/rau_front.sv @@
// Front part: accepts requests, forms cross products one at a time, classifies.
// Depends on rau_pkg.
module rau_front (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  rau_pkg::req_t req,
	output logic busy,
	output logic job_valid,
	output rau_pkg::job_t job,
	input  logic job_full
);
	import rau_pkg::*;

	typedef struct packed { logic neg; logic [OpW-1:0] mag; } sm_t;

	function automatic sm_t to_sm(input logic [OpW-1:0] v);
		sm_t r;
		r.neg = v[OpW-1];
		r.mag = v[OpW-1] ? (~v + 1'b1) : v;
		return r;
	endfunction

	req_t r_q;
	logic [1:0] phase_q;
	logic act_q;
	logic [2*OpW-1:0] p0_q, p1_q, p2_q;
	logic s0_q, s1_q, s2_q;
	logic [1:0] mcnt_q;
	sm_t a, b, c, d, ma, mb;
	logic [2*OpW-1:0] prod;

	assign a = to_sm(r_q.left_num);
	assign b = to_sm(r_q.left_den);
	assign c = to_sm(r_q.right_num);
	assign d = to_sm(r_q.right_den);
	assign busy = act_q;

	// select the multiplier operands for this cycle: one product per cycle
	always_comb begin
		ma = a; mb = d;
		case (mcnt_q)
			2'd0: begin ma = a; mb = d; end
			2'd1: begin ma = b; mb = c; end
			2'd2: begin ma = b; mb = d; end
			default: begin ma = a; mb = c; end
		endcase
	end
	assign prod = {{OpW{1'b0}}, ma.mag} * {{OpW{1'b0}}, mb.mag};

	// accept, multiply, hand over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			phase_q <= 2'd0;
			mcnt_q <= 2'd0;
		end else if (!act_q) begin
			if (start) begin
				act_q <= 1'b1;
				phase_q <= 2'd0;
				mcnt_q <= 2'd0;
			end
		end else if (phase_q == 2'd0) begin
			mcnt_q <= mcnt_q + 2'd1;
			if (mcnt_q == 2'd3) phase_q <= 2'd1;
		end else if (!job_full) begin
			act_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!act_q && start) r_q <= req;
		if (act_q && phase_q == 2'd0) begin
			case (mcnt_q)
				2'd0: begin p0_q <= prod; s0_q <= ma.neg ^ mb.neg; end
				2'd1: begin p1_q <= prod; s1_q <= ma.neg ^ mb.neg; end
				2'd2: begin p2_q <= prod; s2_q <= ma.neg ^ mb.neg; end
				default: begin
					// ad vs cb for divide uses p0, p1; multiply reuses p1 as ac
					if (r_q.req_type == OP_MUL) begin
						p1_q <= prod; s1_q <= ma.neg ^ mb.neg;
					end
				end
			endcase
		end
	end

	assign job_valid = act_q && phase_q == 2'd1 && !job_full;

	// classify and build the job
	always_comb begin
		logic [MagW-1:0] x, y;
		logic xn, yn, cneg;
		op_t op;
		x = '0; y = '0; xn = 1'b0; yn = 1'b0; cneg = 1'b0;
		op = op_t'(r_q.req_type);
		job = '0;
		job.rsp.res_den = {{(OpW-2){1'b0}}, 1'b1};
		job.direct = 1'b1;
		job.rsp.status = ST_OK;
		if (r_q.req_type > OP_NORM) begin
			job.direct = 1'b1;
		end else if (b.mag == '0 || (op != OP_NORM && d.mag == '0)) begin
			job.rsp.status = ST_ZERODEN;
		end else begin
			case (op)
				OP_ADD, OP_SUB: begin
					x = {1'b0, p0_q}; xn = s0_q && p0_q != '0;
					y = {1'b0, p1_q}; yn = (s1_q ^ (op == OP_SUB)) && p1_q != '0;
					if (xn == yn) begin
						job.n = x + y; cneg = xn;
					end else if (x >= y) begin
						job.n = x - y; cneg = xn;
					end else begin
						job.n = y - x; cneg = yn;
					end
					job.d = {1'b0, p2_q};
					// the denominator bd carries a sign of its own
					job.neg = (cneg ^ s2_q) && job.n != '0;
					job.direct = 1'b0;
				end
				OP_MUL: begin
					job.n = {1'b0, p1_q}; job.d = {1'b0, p2_q};
					job.neg = s1_q ^ s2_q;
					job.direct = 1'b0;
				end
				OP_DIV: begin
					if (c.mag == '0) job.rsp.status = ST_DIVZERO;
					else begin
						job.n = {1'b0, p0_q}; job.d = {1'b0, p1_q};
						job.neg = s0_q ^ s1_q;
						job.direct = 1'b0;
					end
				end
				OP_EQ: begin
					job.rsp.is_equal = (p0_q == p1_q) &&
						((s0_q && p0_q != '0) == (s1_q && p1_q != '0));
				end
				default: begin
					job.n = {{(OpW+1){1'b0}}, a.mag};
					job.d = {{(OpW+1){1'b0}}, b.mag};
					job.neg = a.neg ^ b.neg;
					job.direct = 1'b0;
				end
			endcase
			if (job.n == '0) job.neg = 1'b0;
		end
	end
endmodule

@@ hdl/rau_queue.sv @@
// Two-entry job queue between front and back.
// Depends on rau_pkg.
module rau_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rau_pkg::job_t din,
	output logic full,
	output logic nonempty,
	input  logic pop,
	output rau_pkg::job_t dout
);
	import rau_pkg::*;
	job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign nonempty = cnt_q != 2'd0;
	assign dout = mem_q[rp_q];

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end
endmodule

@@ hdl/rau_back.sv @@
// Back part: binary gcd and restoring divisions, then range check.
// Depends on rau_pkg.
module rau_back (
	input  logic clk,
	input  logic arst_n,
	input  logic job_avail,
	input  rau_pkg::job_t job,
	output logic job_pop,
	output logic done,
	output rau_pkg::rsp_t rsp
);
	import rau_pkg::*;
	localparam int CntW = $clog2(MagW + 1);

	bk_state_t st_q, st_d;
	logic [MagW-1:0] n_q, d_q, x_q, y_q, g_q, qn_q, rem_q, quo_q;
	logic neg_q;
	logic [CntW-1:0] cnt_q;
	rsp_t rsp_q;
	logic [MagW-1:0] rem_sh, rem_nx, quo_nx, diff_xy, diff_yx, half;
	logic bit_nx;

	assign half = {{(MagW-OpW){1'b0}}, 1'b1, {(OpW-1){1'b0}}};

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			BK_IDLE: if (job_avail) st_d = job.direct ? BK_OUT : BK_GCD;
			BK_GCD:  if (x_q == '0 || y_q == '0) st_d = BK_DIVN;
			BK_DIVN: if (cnt_q == CntW'(MagW-1)) st_d = BK_DIVD;
			BK_DIVD: if (cnt_q == CntW'(MagW-1)) st_d = BK_OUT;
			BK_OUT:  st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		job_pop = st_q == BK_IDLE && job_avail;
		done = st_q == BK_OUT;
		rsp = rsp_q;
	end

	// one restoring division step
	assign rem_sh = {rem_q[MagW-2:0], quo_q[MagW-1]};
	assign bit_nx = rem_sh >= g_q;
	assign rem_nx = bit_nx ? rem_sh - g_q : rem_sh;
	assign quo_nx = {quo_q[MagW-2:0], bit_nx};
	assign diff_xy = x_q - y_q;
	assign diff_yx = y_q - x_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= BK_IDLE;
		else st_q <= st_d;
	end

	// datapath: one binary gcd step per cycle, each step drops at least one bit,
	// so at most 2*MagW steps; common factors of two are counted in cnt_q
	always_ff @(posedge clk) begin
		case (st_q)
			BK_IDLE: begin
				n_q <= job.n; d_q <= job.d; neg_q <= job.neg;
				x_q <= job.n; y_q <= job.d; cnt_q <= '0;
				rsp_q <= job.rsp;
			end
			BK_GCD: begin
				if (x_q == '0 || y_q == '0) begin
					g_q <= (x_q | y_q) << cnt_q;
					cnt_q <= '0; rem_q <= '0; quo_q <= n_q;
				end else if (!x_q[0] && !y_q[0]) begin
					x_q <= x_q >> 1; y_q <= y_q >> 1; cnt_q <= cnt_q + 1'b1;
				end else if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else if (x_q >= y_q) begin
					x_q <= diff_xy >> 1;
				end else begin
					y_q <= diff_yx >> 1;
				end
			end
			BK_DIVN, BK_DIVD: begin
				if (cnt_q == CntW'(MagW-1)) begin
					cnt_q <= '0; rem_q <= '0;
					if (st_q == BK_DIVN) begin
						qn_q <= quo_nx;
						quo_q <= d_q;
					end else begin
						// range check on the reduced pair
						if (quo_nx > half - 1'b1 ||
							(neg_q ? qn_q > half : qn_q > half - 1'b1)) begin
							rsp_q.res_num <= '0;
							rsp_q.res_den <= {{(OpW-2){1'b0}}, 1'b1};
							rsp_q.is_equal <= 1'b0;
							rsp_q.status <= ST_OVERFLOW;
						end else begin
							rsp_q.res_num <= neg_q ? (~qn_q[OpW-1:0] + 1'b1) :
								qn_q[OpW-1:0];
							rsp_q.res_den <= quo_nx[OpW-2:0];
							rsp_q.is_equal <= 1'b0;
							rsp_q.status <= ST_OK;
						end
					end
				end else begin
					rem_q <= rem_nx; quo_q <= quo_nx;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			BK_OUT: ;
			default: ;
		endcase
	end
endmodule

@@ hdl/rational_arithmetic_unit.sv @@
// Top level of the rational arithmetic unit.
// Depends on rau_pkg, rau_front, rau_queue, rau_back.
//
// Usage: drive req and pulse start while busy is low; the request is taken
// at that edge. The front forms the cross products, one 32x32 product per
// cycle, and queues a classified job. The back reduces it: a binary gcd on
// 65-bit magnitudes, then two restoring divisions, then an output state.
// Error, equal and unknown-opcode cases skip the reduction and go straight
// to the output state. The front may take the next request while the back
// still works. Each result shows on rsp for one cycle with done high; the
// receiver cannot stall. Reset clears all control state and the queue.
// The operand width is the package constant OpW.
module rational_arithmetic_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  rau_pkg::req_t req,
	output logic busy,
	output logic done,
	output rau_pkg::rsp_t rsp
);
	import rau_pkg::*;

	job_t fjob, qjob;
	logic fvalid, qfull, qne, qpop;

	rau_front u_front (.clk, .arst_n, .start, .req, .busy, .job_valid(fvalid),
		.job(fjob), .job_full(qfull));
	rau_queue u_queue (.clk, .arst_n, .push(fvalid), .din(fjob), .full(qfull),
		.nonempty(qne), .pop(qpop), .dout(qjob));
	rau_back u_back (.clk, .arst_n, .job_avail(qne), .job(qjob), .job_pop(qpop),
		.done, .rsp);
endmodule

@@ hdl/rau_checker.sv @@
// Port-level checker for the rational arithmetic unit, bound to the top.
// Depends on rau_pkg.
module rau_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rau_pkg::rsp_t rsp
);
	import rau_pkg::*;
	a_acc: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("request not taken");
	a_den: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.res_den != '0) else $error("zero denominator out");
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != ST_OK |-> rsp.res_num == '0) else $error("error payload");
	a_eq: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.is_equal |-> rsp.status == ST_OK) else $error("equal flag");
	a_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done not a pulse");
endmodule

bind rational_arithmetic_unit rau_checker u_chk (.clk, .arst_n, .start, .busy, .done, .rsp);

@@ bench/rational_arithmetic_unit_tb.sv @@
// Testbench for the rational arithmetic unit: directed table plus random requests,
// each result checked against an in-bench fraction predictor.
// Depends on rau_pkg and the rational_arithmetic_unit RTL.
module rational_arithmetic_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rau_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int RANDOM_REQS = 1430;

	logic clk;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	rsp_t rsp;

	rsp_t expected_q[$];
	int err_count;
	int cycle_count;
	int send_idle_pct;

	typedef struct {
		req_t r;
		bit typed;
		rsp_t want;
	} vec_t;
	vec_t vecs[$];

	rational_arithmetic_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Build a result record
	function automatic rsp_t mk_rsp(logic signed [31:0] n, logic [30:0] d, logic e,
			status_t s);
		rsp_t o;
		o.res_num = n;
		o.res_den = d;
		o.is_equal = e;
		o.status = s;
		return o;
	endfunction

	function automatic logic [64:0] gcd65(logic [64:0] x, logic [64:0] y);
		logic [64:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// Reduce n/d, sign on numerator, range check
	function automatic rsp_t reduce_fraction(logic signed [66:0] n, logic signed [66:0] d);
		logic [64:0] nm, dm, g;
		logic neg;
		nm = n < 0 ? -n : n;
		dm = d < 0 ? -d : d;
		neg = ((n < 0) != (d < 0)) && nm != 0;
		g = gcd65(nm, dm);
		if (g == 0) g = 1;
		nm = nm / g;
		dm = dm / g;
		if (dm > 65'h7fffffff || (neg ? nm > 65'h80000000 : nm > 65'h7fffffff))
			return mk_rsp(0, 1, 0, ST_OVERFLOW);
		return mk_rsp(neg ? -nm[31:0] : nm[31:0], dm[30:0], 0, ST_OK);
	endfunction

	function automatic rsp_t rational_result(req_t r);
		logic signed [66:0] a, b, c, d;
		a = r.left_num;
		b = r.left_den;
		c = r.right_num;
		d = r.right_den;
		if (r.req_type > OP_NORM) return mk_rsp(0, 1, 0, ST_OK);
		if (b == 0 || (r.req_type != OP_NORM && d == 0)) return mk_rsp(0, 1, 0, ST_ZERODEN);
		case (r.req_type)
			OP_ADD: return reduce_fraction(a * d + b * c, b * d);
			OP_SUB: return reduce_fraction(a * d - b * c, b * d);
			OP_MUL: return reduce_fraction(a * c, b * d);
			OP_DIV: begin
				if (c == 0) return mk_rsp(0, 1, 0, ST_DIVZERO);
				return reduce_fraction(a * d, b * c);
			end
			OP_EQ: return mk_rsp(0, 1, (a * d == b * c), ST_OK);
			default: return reduce_fraction(a, b);
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [65:0] got, logic [65:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	function automatic req_t mk_req(logic [2:0] op, logic [31:0] a, logic [31:0] b,
			logic [31:0] c, logic [31:0] d);
		req_t r;
		r.req_type = op;
		r.left_num = a;
		r.left_den = b;
		r.right_num = c;
		r.right_den = d;
		return r;
	endfunction

	task automatic add_vec(req_t r, bit typed = 0, rsp_t want = '0);
		vec_t v;
		v.r = r;
		v.typed = typed;
		v.want = want;
		vecs.push_back(v);
	endtask

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 7))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return 0;
			3: return $urandom_range(0, 1) ? 32'hffffffff : 32'h1;
			4, 5: return $signed($urandom_range(0, 40)) - 20;
			default: return $urandom;
		endcase
	endfunction

	// Drive one request at the falling edge and hold until it is taken
	task automatic send_request(req_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		req <= r;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		expected_q.push_back(rational_result(r));
		@(negedge clk);
	endtask

	// Check each strobed result against the oldest expectation
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				$display("unexpected result at %0t", $realtime);
				err_count++;
			end else begin
				want = expected_q.pop_front();
				if (rsp.res_num !== want.res_num)
					report_mismatch("res_num", 66'(rsp.res_num), 66'(want.res_num));
				if (rsp.res_den !== want.res_den)
					report_mismatch("res_den", 66'(rsp.res_den), 66'(want.res_den));
				if (rsp.is_equal !== want.is_equal)
					report_mismatch("is_equal", 66'(rsp.is_equal), 66'(want.is_equal));
				if (rsp.status !== want.status)
					report_mismatch("status", 66'(rsp.status), 66'(want.status));
			end
		end
	end

	// Abort on runaway
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("rational_arithmetic_unit_tb: errors");
			$finish;
		end
	end

	initial begin
		rsp_t pred;
		int n;
		err_count = 0;
		cycle_count = 0;
		start = 1'b0;
		req = '0;
		send_idle_pct = 28;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table
		add_vec(mk_req(OP_ADD, 1, 2, 1, 3), 1, mk_rsp(5, 6, 0, ST_OK));
		add_vec(mk_req(OP_SUB, 1, 2, 1, 2), 1, mk_rsp(0, 1, 0, ST_OK));
		add_vec(mk_req(OP_MUL, 2, 3, 3, 4), 1, mk_rsp(1, 2, 0, ST_OK));
		add_vec(mk_req(OP_DIV, 1, 2, 0, 5), 1, mk_rsp(0, 1, 0, ST_DIVZERO));
		add_vec(mk_req(OP_DIV, 1, 2, 3, 4), 1, mk_rsp(2, 3, 0, ST_OK));
		add_vec(mk_req(OP_EQ, 1, 2, -2, -4), 1, mk_rsp(0, 1, 1, ST_OK));
		add_vec(mk_req(OP_EQ, 1, 2, 1, 3), 1, mk_rsp(0, 1, 0, ST_OK));
		add_vec(mk_req(OP_NORM, 4, -8, 0, 0), 1, mk_rsp(-1, 2, 0, ST_OK));
		add_vec(mk_req(OP_NORM, 32'h80000000, -1, 0, 0), 1, mk_rsp(0, 1, 0, ST_OVERFLOW));
		add_vec(mk_req(OP_NORM, 5, 0, 1, 1), 1, mk_rsp(0, 1, 0, ST_ZERODEN));
		add_vec(mk_req(OP_ADD, 5, 1, 1, 0), 1, mk_rsp(0, 1, 0, ST_ZERODEN));
		add_vec(mk_req(OP_DIV, 5, 0, 0, 1), 1, mk_rsp(0, 1, 0, ST_ZERODEN));
		add_vec(mk_req(3'd6, 5, 1, 1, 1), 1, mk_rsp(0, 1, 0, ST_OK));
		add_vec(mk_req(3'd7, -1, -1, -1, -1), 1, mk_rsp(0, 1, 0, ST_OK));
		add_vec(mk_req(OP_MUL, 0, 7, 3, 5), 1, mk_rsp(0, 1, 0, ST_OK));
		add_vec(mk_req(OP_NORM, 32'h80000000, 1, 0, 0), 1, mk_rsp(32'h80000000, 1, 0, ST_OK));
		add_vec(mk_req(OP_NORM, 1, 32'h80000000, 0, 0), 1, mk_rsp(0, 1, 0, ST_OVERFLOW));
		add_vec(mk_req(OP_MUL, 32'h7fffffff, 1, 32'h7fffffff, 1));
		add_vec(mk_req(OP_ADD, 32'h7fffffff, 32'h7ffffffe, 32'h80000000, 32'h7fffffff));
		add_vec(mk_req(OP_SUB, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000));
		add_vec(mk_req(OP_DIV, 32'h80000000, 3, 32'h80000000, -3));
		add_vec(mk_req(OP_EQ, 32'hffffffff, 32'hffffffff, 32'h7fffffff, 32'h7fffffff));
		foreach (vecs[i]) begin
			if (vecs[i].typed) begin
				pred = rational_result(vecs[i].r);
				if (pred !== vecs[i].want) report_mismatch("table", pred, vecs[i].want);
			end
			send_request(vecs[i].r);
		end

		// Random requests in three idle phases
		for (int i = 0; i < RANDOM_REQS; i++) begin
			if (i == RANDOM_REQS / 3) send_idle_pct = 87;
			if (i == 2 * RANDOM_REQS / 3) send_idle_pct = 0;
			n = $urandom_range(0, 99);
			send_request(mk_req(n < 3 ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5)),
				rand_operand(), rand_operand(), rand_operand(), rand_operand()));
		end
		start <= 1'b0;

		// Drain then allow the back end to settle
		while (expected_q.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (err_count == 0)
			$display("rational_arithmetic_unit_tb: clean");
		else
			$display("rational_arithmetic_unit_tb: errors");
		$finish;
	end
endmodule
